// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pbt_pkg.sv =====
`timescale 1ns / 1ps

package pbt_pkg;

	localparam int PID_W    = 32;
	localparam int TIME_W   = 63;
	localparam int COUNT_W  = 16;
	localparam int WINDOW_W = 40;
	localparam int THRESH_W = 16;
	localparam int WEIGHT_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 2'd2;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 40'd30000000;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd5;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [PID_W-1:0]   owner;
		logic [COUNT_W-1:0] count;
		logic [TIME_W-1:0]  last_time;
	} slot_t;

endpackage

// ===== src/per_process_burst_tracker.sv =====
`timescale 1ns / 1ps

// Per-process burst tracker. Each qualifying word scans the slot table held in a synchronous
// memory with one read and one write port, one slot per cycle starting at slot 0, until the
// owning slot is found or the table ends, then writes the updated slot back. The word is
// accepted, the slots are scanned, the slot is written back and the output register is loaded,
// which offers the result; the load waits while an earlier result is held and out_ready is low.
// A word that does not qualify skips scan and write-back and yields alarm 0. The result waits in
// an output register while the next word is accepted. Reset clears the table at once through
// per-slot valid bits; no clearing pass is needed. Configuration writes are always accepted and
// must only be issued when idle.

`include "assert_macros.svh"

module per_process_burst_tracker
	import pbt_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PID_W-1:0]     process_id,
	input  logic [TIME_W-1:0]    now_time,
	input  logic                 qualifies,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 alarm,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WINDOW_W-1:0]  cfg_data
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE, ST_EMIT} state_t;

	state_t state_q;

	slot_t mem [SLOTS];
	slot_t rd_q;
	slot_t eff;
	slot_t wr_data;

	logic [SLOTS-1:0]    valid_q;
	logic [WINDOW_W-1:0] window_q;
	logic [THRESH_W-1:0] thresh_q;
	logic [WEIGHT_W-1:0] weight_q;

	logic [PID_W-1:0]   pid_q;
	logic [TIME_W-1:0]  now_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   old_idx_q;
	logic [TIME_W-1:0]  old_time_q;
	logic [IDX_W-1:0]   cand_q;
	logic               cand_found_q;
	logic [IDX_W-1:0]   slot_q;
	logic [COUNT_W-1:0] base_q;
	logic               res_q;
	logic               out_valid_q;
	logic               alarm_q;

	logic               in_acc;
	logic               is_last;
	logic               hit;
	logic               expired;
	logic               older;
	logic               free_now;
	logic [TIME_W-1:0]  age;
	logic [COUNT_W:0]   sum;
	logic [COUNT_W-1:0] new_count;
	logic               wr_en;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign alarm     = alarm_q;

	assign is_last = (idx_q == LAST_IDX);
	assign rd_addr = (state_q == ST_IDLE || is_last) ? '0 : idx_q + 1'b1;

	assign eff      = valid_q[idx_q] ? rd_q : '0;
	assign age      = now_q - eff.last_time;
	assign expired  = (now_q > eff.last_time) && (age > TIME_W'(window_q));
	assign hit      = (eff.owner == pid_q);
	assign older    = (idx_q == '0) || (eff.last_time < old_time_q);
	assign free_now = (eff.owner == '0) || expired;

	assign sum       = {1'b0, base_q} + (COUNT_W + 1)'(weight_q);
	assign new_count = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
	assign wr_en     = (state_q == ST_WRITE);
	assign wr_data   = '{owner: pid_q, count: new_count, last_time: now_q};

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (wr_en) begin
			mem[slot_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			thresh_q <= THRESH_RESET;
			weight_q <= WEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WINDOW:    window_q <= cfg_data;
				REG_THRESHOLD: thresh_q <= cfg_data[THRESH_W-1:0];
				REG_WEIGHT:    weight_q <= cfg_data[WEIGHT_W-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			out_valid_q  <= 1'b0;
			cand_found_q <= 1'b0;
			idx_q        <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pid_q        <= process_id;
						now_q        <= now_time;
						idx_q        <= '0;
						cand_found_q <= 1'b0;
						res_q        <= 1'b0;
						state_q      <= qualifies ? ST_SCAN : ST_EMIT;
					end
				end
				ST_SCAN: begin
					if (older) begin
						old_idx_q  <= idx_q;
						old_time_q <= eff.last_time;
					end
					if (hit) begin
						slot_q  <= idx_q;
						base_q  <= expired ? '0 : eff.count;
						state_q <= ST_WRITE;
					end else begin
						if (!cand_found_q && free_now) begin
							cand_q       <= idx_q;
							cand_found_q <= 1'b1;
						end
						if (is_last) begin
							priority if (cand_found_q) begin
								slot_q <= cand_q;
							end else if (free_now || older) begin
								slot_q <= idx_q;
							end else begin
								slot_q <= old_idx_q;
							end
							base_q  <= '0;
							state_q <= ST_WRITE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_WRITE: begin
					valid_q[slot_q] <= 1'b1;
					res_q           <= (new_count >= thresh_q);
					state_q         <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						alarm_q     <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_NEXT(a_nonqual_emits_zero, clk, arst_n, in_acc && !qualifies, (state_q == ST_EMIT) && !res_q, "non-qualifying word did not go straight to a zero result")
	`ASSERT_NEXT(a_write_then_emit, clk, arst_n, state_q == ST_WRITE, (state_q == ST_EMIT) && valid_q[$past(slot_q)], "write-back did not mark the slot valid and offer the result")
	`ASSERT_IMPL(a_scan_index_range, clk, arst_n, state_q == ST_SCAN, idx_q <= LAST_IDX, "scan index ran past the table")
	`ASSERT_NEXT(a_emit_loads_output, clk, arst_n, (state_q == ST_EMIT) && (!out_valid_q || out_ready), out_valid_q && (alarm_q == $past(res_q)), "result not loaded into the output register")

endmodule
